// ===== rtl/u8u16_pkg.sv =====
// shared types and constants for the utf-8 to utf-16 transcoder
// used by every module of the block, no dependencies

package u8u16_pkg;

  // largest output buffer the block supports, in 16-bit units
  localparam int unsigned MAX_CAPACITY = 1048576;

  localparam int unsigned CAP_W  = 21;
  localparam int unsigned UNIT_W = 16;
  localparam int unsigned BYTE_W = 8;

  // capacity in use is clamped to this, reset value of the capacity register
  localparam logic [CAP_W:0] CAP_LIMIT =
    (MAX_CAPACITY > 2097151) ? 22'd2097151 : 22'(MAX_CAPACITY);

  localparam logic [UNIT_W-1:0] HI_SURR_BASE = 16'hD800;
  localparam logic [UNIT_W-1:0] LO_SURR_BASE = 16'hDC00;
  localparam logic [CAP_W-1:0]  SUPP_OFFSET  = 21'h10000;

  // depth of the command queue between front and back
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);

  typedef enum logic [1:0] {
    ST_UNIT    = 2'd0,
    ST_DONE    = 2'd1,
    ST_INVALID = 2'd2,
    ST_NOROOM  = 2'd3
  } status_e;

  // one queued command: a single result or a surrogate pair
  typedef struct packed {
    logic [UNIT_W-1:0] unit0;
    logic [UNIT_W-1:0] unit1;
    logic [CAP_W-1:0]  index;
    status_e           status;
    logic              pair;
  } cmd_t;

endpackage

// ===== rtl/u8u16_front.sv =====
// front end: accepts bytes, decodes utf-8 sequences, checks buffer room
// and builds one command per result-bearing word; depends on u8u16_pkg

module u8u16_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [u8u16_pkg::CAP_W-1:0]  cfg_wdata_i,
  input  logic                      in_valid_i,
  input  logic [u8u16_pkg::BYTE_W-1:0] in_byte_i,
  input  logic                      q_full_i,
  output logic                      push_o,
  output u8u16_pkg::cmd_t           cmd_o
);
  import u8u16_pkg::*;

  logic [CAP_W-1:0] cap_q;
  logic [1:0]       rem_q, rem_d;
  logic [CAP_W-1:0] acc_q, acc_d;
  logic [CAP_W-1:0] uw_q, uw_d;
  logic             err_q, err_d;

  logic             accept;
  logic [CAP_W-1:0] cap_use;
  logic [CAP_W-1:0] acc_next;
  logic [CAP_W-1:0] cp;
  logic             do_emit;
  logic [CAP_W-1:0] supp;
  logic             room1, room2, room0;
  logic [1:0]       rem_dec;

  assign accept   = in_valid_i & ~q_full_i;
  assign cap_use  = ({1'b0, cap_q} > CAP_LIMIT) ? CAP_LIMIT[CAP_W-1:0] : cap_q;
  assign acc_next = {acc_q[CAP_W-7:0], in_byte_i[5:0]};
  assign rem_dec  = rem_q - 2'd1;
  assign supp     = cp - SUPP_OFFSET;
  assign room0    = uw_q < cap_use;
  assign room1    = ({1'b0, uw_q} + 22'd1) < {1'b0, cap_use};
  assign room2    = ({1'b0, uw_q} + 22'd2) < {1'b0, cap_use};

  always_comb begin
    rem_d   = rem_q;
    acc_d   = acc_q;
    uw_d    = uw_q;
    err_d   = err_q;
    push_o  = 1'b0;
    do_emit = 1'b0;
    cp      = '0;
    cmd_o.unit0  = '0;
    cmd_o.unit1  = '0;
    cmd_o.index  = uw_q;
    cmd_o.status = ST_UNIT;
    cmd_o.pair   = 1'b0;

    if (accept) begin
      if (in_byte_i == '0) begin
        // end of string: terminator unless muted, then re-arm
        if (!err_q) begin
          push_o = 1'b1;
          if (rem_q != 2'd0) begin
            cmd_o.status = ST_INVALID;
          end else if (!room0) begin
            cmd_o.status = ST_NOROOM;
          end else begin
            cmd_o.status = ST_DONE;
          end
        end
        rem_d = '0;
        acc_d = '0;
        uw_d  = '0;
        err_d = 1'b0;
      end else if (!err_q) begin
        if (rem_q == 2'd0) begin
          if (!in_byte_i[7]) begin
            do_emit = 1'b1;
            cp      = {13'd0, in_byte_i};
          end else if (in_byte_i[7:5] == 3'b110) begin
            acc_d = {16'd0, in_byte_i[4:0]};
            rem_d = 2'd1;
          end else if (in_byte_i[7:4] == 4'b1110) begin
            acc_d = {17'd0, in_byte_i[3:0]};
            rem_d = 2'd2;
          end else if (in_byte_i[7:3] == 5'b11110) begin
            acc_d = {18'd0, in_byte_i[2:0]};
            rem_d = 2'd3;
          end else begin
            err_d        = 1'b1;
            push_o       = 1'b1;
            cmd_o.status = ST_INVALID;
          end
        end else begin
          rem_d = rem_dec;
          if (rem_dec == 2'd0) begin
            acc_d   = '0;
            do_emit = 1'b1;
            cp      = acc_next;
          end else begin
            acc_d = acc_next;
          end
        end
      end

      if (do_emit) begin
        push_o = 1'b1;
        if (cp[CAP_W-1:UNIT_W] != '0) begin
          // supplementary plane: surrogate pair
          if (!room2) begin
            err_d        = 1'b1;
            cmd_o.status = ST_NOROOM;
          end else begin
            cmd_o.unit0 = HI_SURR_BASE + {5'd0, supp[CAP_W-1:10]};
            cmd_o.unit1 = LO_SURR_BASE + {6'd0, supp[9:0]};
            cmd_o.pair  = 1'b1;
            uw_d        = uw_q + 21'd2;
          end
        end else if (!room1) begin
          err_d        = 1'b1;
          cmd_o.status = ST_NOROOM;
        end else begin
          cmd_o.unit0 = cp[UNIT_W-1:0];
          uw_d        = uw_q + 21'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_LIMIT[CAP_W-1:0];
      rem_q <= '0;
      acc_q <= '0;
      uw_q  <= '0;
      err_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      rem_q <= rem_d;
      acc_q <= acc_d;
      uw_q  <= uw_d;
      err_q <= err_d;
    end
  end

endmodule

// ===== rtl/u8u16_queue.sv =====
// small command queue between front and back end
// depends on u8u16_pkg for the command type and depth

module u8u16_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  u8u16_pkg::cmd_t push_cmd_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            not_empty_o,
  output u8u16_pkg::cmd_t head_o
);
  import u8u16_pkg::*;

  cmd_t               slot_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_q, rd_q;
  logic [Q_PTR_W:0]   cnt_q;

  assign full_o      = cnt_q == (Q_PTR_W+1)'(Q_DEPTH);
  assign not_empty_o = cnt_q != '0;
  assign head_o      = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/u8u16_back.sv =====
// back end: presents queued commands as result words, splitting
// surrogate pairs over two handshakes; depends on u8u16_pkg

module u8u16_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         head_valid_i,
  input  u8u16_pkg::cmd_t              head_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [u8u16_pkg::UNIT_W-1:0] out_unit_o,
  output logic [u8u16_pkg::CAP_W-1:0]  out_index_o,
  output logic [1:0]                   status_o,
  output logic                         last_o
);
  import u8u16_pkg::*;

  logic phase_q;
  logic fire;

  assign out_valid_o = head_valid_i;
  assign fire        = head_valid_i & ~out_stall_i;
  assign last_o      = ~head_i.pair | phase_q;
  assign pop_o       = fire & last_o;
  assign out_unit_o  = phase_q ? head_i.unit1 : head_i.unit0;
  assign out_index_o = phase_q ? head_i.index + 21'd1 : head_i.index;
  assign status_o    = head_i.status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
    end else if (fire) begin
      phase_q <= head_i.pair & ~phase_q;
    end
  end

endmodule

// ===== rtl/utf8_to_utf16_transcoder_core.sv =====
// utf-8 to utf-16 transcoder, one byte word in, up to two unit words out
// a result is registered in the command queue before it is offered
// throughput: one byte per cycle while the queue has a free slot; a surrogate pair leaves as two unit words
// a four-entry command queue lets input and output stall independently
// reset clears sequence state, unit count and error hold; capacity resets to max

module utf8_to_utf16_transcoder_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // capacity register write
  input  logic                         cfg_we_i,
  input  logic [u8u16_pkg::CAP_W-1:0]  cfg_wdata_i,
  // byte input channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [u8u16_pkg::BYTE_W-1:0] in_byte_i,
  // unit output channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [u8u16_pkg::UNIT_W-1:0] out_unit_o,
  output logic [u8u16_pkg::CAP_W-1:0]  out_index_o,
  output logic [1:0]                   status_o,
  output logic                         last_o
);
  import u8u16_pkg::*;

  // front to queue
  logic q_full;
  logic push;
  cmd_t push_cmd;

  // queue to back
  logic q_not_empty;
  logic pop;
  cmd_t head;

  // input stalls only when the queue has no free slot
  assign in_stall_o = q_full;

  // decode and room check, holds all per-string state and the capacity
  u8u16_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_byte_i   (in_byte_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  // decoupling queue, also serves as the output register
  u8u16_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_cmd_i  (push_cmd),
    .pop_i       (pop),
    .full_o      (q_full),
    .not_empty_o (q_not_empty),
    .head_o      (head)
  );

  // result sequencing, splits surrogate pairs
  u8u16_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_not_empty),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_unit_o   (out_unit_o),
    .out_index_o  (out_index_o),
    .status_o     (status_o),
    .last_o       (last_o)
  );

endmodule

// ===== test/u8u16_unit_checker.sv =====
// checker for the utf-8 to utf-16 transcoder: predicts unit words from accepted bytes
// and compares them with the unit words leaving the block
// depends on u8u16_pkg for widths, capacity limit, surrogate bases and status codes
`timescale 1ns / 1ps

module u8u16_unit_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [u8u16_pkg::CAP_W-1:0]  cfg_wdata_i,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic [u8u16_pkg::BYTE_W-1:0] in_byte_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic [u8u16_pkg::UNIT_W-1:0] out_unit_i,
  input  logic [u8u16_pkg::CAP_W-1:0]  out_index_i,
  input  logic [1:0]                   status_i,
  input  logic                         last_i,
  output int unsigned                  in_flight_o,
  output int unsigned                  fail_count_o,
  output int unsigned                  words_seen_o
);
  import u8u16_pkg::*;

  localparam logic [CAP_W-1:0] CAP_RESET =
    (MAX_CAPACITY > 32'h1FFFFF) ? 21'h1FFFFF : CAP_W'(MAX_CAPACITY);
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [UNIT_W-1:0] code_unit;
    logic [CAP_W-1:0]  position;
    status_e           status;
    logic              is_last;
  } unit_word_t;

  unit_word_t       expected_units[$];
  logic [CAP_W-1:0] capacity;
  logic [1:0]       bytes_left;
  logic [CAP_W-1:0] cp_acc;
  logic [CAP_W-1:0] units_done;
  logic             muted;
  int unsigned      n_fail;
  int unsigned      n_words;

  function automatic int unsigned cap_used();
    return (32'(capacity) > MAX_CAPACITY) ? MAX_CAPACITY : 32'(capacity);
  endfunction

  task automatic expect_word(input logic [UNIT_W-1:0] cu, input logic [CAP_W-1:0] pos,
                             input status_e st, input logic lst);
    expected_units.push_back(unit_word_t'{cu, pos, st, lst});
  endtask

  // one unit, or a surrogate pair above the bmp; room for the terminator is kept
  task automatic emit_code_point(input logic [CAP_W-1:0] cp);
    logic [31:0] v;
    if (cp[CAP_W-1:16] != '0) begin
      if (32'(units_done) + 32'd2 >= cap_used()) begin
        muted = 1'b1;
        expect_word('0, units_done, ST_NOROOM, 1'b1);
      end else begin
        v = 32'(cp) - 32'(SUPP_OFFSET);
        expect_word(UNIT_W'(32'(HI_SURR_BASE) + (v >> 10)), units_done, ST_UNIT, 1'b0);
        expect_word(UNIT_W'(32'(LO_SURR_BASE) + (v & 32'h3FF)), units_done + 1'b1,
                    ST_UNIT, 1'b1);
        units_done = units_done + 2'd2;
      end
    end else if (32'(units_done) + 32'd1 >= cap_used()) begin
      muted = 1'b1;
      expect_word('0, units_done, ST_NOROOM, 1'b1);
    end else begin
      expect_word(cp[UNIT_W-1:0], units_done, ST_UNIT, 1'b1);
      units_done = units_done + 1'b1;
    end
  endtask

  task automatic transcode_byte(input logic [BYTE_W-1:0] b);
    if (b == '0) begin
      if (!muted) begin
        if (bytes_left != '0) begin
          expect_word('0, units_done, ST_INVALID, 1'b1);
        end else if (32'(units_done) >= cap_used()) begin
          expect_word('0, units_done, ST_NOROOM, 1'b1);
        end else begin
          expect_word('0, units_done, ST_DONE, 1'b1);
        end
      end
      bytes_left = '0;
      cp_acc     = '0;
      units_done = '0;
      muted      = 1'b0;
    end else if (!muted) begin
      if (bytes_left == '0) begin
        if (!b[7]) begin
          emit_code_point(CAP_W'(b));
        end else if (b[7:5] == 3'b110) begin
          cp_acc     = CAP_W'(b[4:0]);
          bytes_left = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
          cp_acc     = CAP_W'(b[3:0]);
          bytes_left = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
          cp_acc     = CAP_W'(b[2:0]);
          bytes_left = 2'd3;
        end else begin
          muted = 1'b1;
          expect_word('0, units_done, ST_INVALID, 1'b1);
        end
      end else begin
        // tail bytes are taken as they come, low six bits only
        cp_acc     = {cp_acc[CAP_W-7:0], b[5:0]};
        bytes_left = bytes_left - 2'd1;
        if (bytes_left == '0) begin
          emit_code_point(cp_acc);
          cp_acc = '0;
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    unit_word_t want;
    if (!rst_ni) begin
      expected_units.delete();
      capacity   = CAP_RESET;
      bytes_left = '0;
      cp_acc     = '0;
      units_done = '0;
      muted      = 1'b0;
      n_fail     = 0;
      n_words    = 0;
    end else begin
      if (cfg_we_i) capacity = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) transcode_byte(in_byte_i);
      if (out_valid_i && !out_stall_i) begin
        n_words++;
        if (expected_units.size() == 0) begin
          if (n_fail < MAX_REPORTS)
            $display("unexpected word %0d: unit %h index %0d status %0d last %b",
                     n_words, out_unit_i, out_index_i, status_i, last_i);
          n_fail++;
        end else begin
          want = expected_units.pop_front();
          if (out_unit_i !== want.code_unit || out_index_i !== want.position ||
              status_i !== want.status || last_i !== want.is_last) begin
            if (n_fail < MAX_REPORTS)
              $display({"word %0d mismatch: expected unit %h index %0d status %0d last %b,",
                        " got unit %h index %0d status %0d last %b"},
                       n_words, want.code_unit, want.position, want.status, want.is_last,
                       out_unit_i, out_index_i, status_i, last_i);
            n_fail++;
          end
        end
      end
    end
    in_flight_o  <= expected_units.size();
    fail_count_o <= n_fail;
    words_seen_o <= n_words;
  end

endmodule

// ===== test/tb.sv =====
// top of the transcoder testbench: clock, reset, byte stimulus, output stalls, verdict
// depends on u8u16_pkg, utf8_to_utf16_transcoder_core and u8u16_unit_checker
`timescale 1ns / 1ps

module tb;
  import u8u16_pkg::*;

  // timeout for the whole run, set with plenty of margin
  localparam int unsigned LIMIT_CYCLES  = 300000;
  localparam int unsigned HOLD_CYCLES   = 120;
  localparam int unsigned HOLD_AFTER    = 150;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned DRAIN_CYCLES  = 20;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic [CAP_W-1:0]  cfg_wdata_i = '0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  logic [BYTE_W-1:0] in_byte_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [UNIT_W-1:0] out_unit_o;
  logic [CAP_W-1:0]  out_index_o;
  logic [1:0]        status_o;
  logic              last_o;

  // output stall is the per-word draw or the long hold-off, whichever is active
  logic rx_stall = 1'b0;
  logic rx_hold  = 1'b0;
  assign out_stall_i = rx_stall | rx_hold;

  // sender runs without gaps while this is set
  logic        tx_quiet   = 1'b0;
  int unsigned n_sent     = 0;
  int unsigned n_cycles   = 0;
  int unsigned n_settings = 1;
  int unsigned in_flight;
  int unsigned fail_count;
  int unsigned words_seen;

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) n_cycles <= n_cycles + 1;

  utf8_to_utf16_transcoder_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_byte_i   (in_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_unit_o  (out_unit_o),
    .out_index_o (out_index_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

  u8u16_unit_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_byte_i    (in_byte_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_unit_i   (out_unit_o),
    .out_index_i  (out_index_o),
    .status_i     (status_o),
    .last_i       (last_o),
    .in_flight_o  (in_flight),
    .fail_count_o (fail_count),
    .words_seen_o (words_seen)
  );

  // offer one byte word after a random gap and hold it until the block takes it
  // valid is lowered only for a gap and raised again when the byte is offered
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int unsigned gap;
    gap = (tx_quiet || rx_hold) ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    n_sent++;
  endtask

  // tail byte, now and then any nonzero byte in place of the 10xxxxxx form
  task automatic send_cont();
    send_byte(($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255))
                                          : {2'b10, 6'($urandom_range(0, 63))});
  endtask

  // one character of 1 to 4 bytes with random payload bits, tail bytes from send_cont
  task automatic send_char();
    int unsigned n_cont;
    case ($urandom_range(0, 3))
      0: begin
        send_byte(8'($urandom_range(1, 127)));
        n_cont = 0;
      end
      1: begin
        send_byte({3'b110, 5'($urandom_range(0, 31))});
        n_cont = 1;
      end
      2: begin
        send_byte({4'b1110, 4'($urandom_range(0, 15))});
        n_cont = 2;
      end
      default: begin
        send_byte({5'b11110, 3'($urandom_range(0, 7))});
        n_cont = 3;
      end
    endcase
    repeat (n_cont) send_cont();
  endtask

  // a nul-terminated string: mostly whole characters, some stray bytes,
  // cut-off sequences and nul bytes in the middle of a sequence
  task automatic send_string();
    int unsigned n_chars;
    int unsigned pick;
    tx_quiet = ($urandom_range(0, 7) == 0);
    n_chars  = $urandom_range(0, 12);
    repeat (n_chars) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        send_char();
      end else if (pick < 91) begin
        send_byte(8'($urandom_range(1, 255)));
      end else if (pick < 96) begin
        // lead byte whose tail never comes, the next character feeds it
        send_byte({2'b11, 6'($urandom_range(0, 55))});
      end else begin
        send_byte({2'b11, 6'($urandom_range(0, 55))});
        send_byte(8'h00);
      end
    end
    send_byte(8'h00);
  endtask

  // drain, let the last result-less bytes settle, set the capacity, then run strings
  task automatic run_phase(input logic [CAP_W-1:0] cap, input int unsigned upto);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (in_flight != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    n_settings++;
    while (n_sent < upto) send_string();
  endtask

  // output side: random stall before each word, with stall-free stretches
  initial begin : receiver
    int unsigned gap;
    bit          quiet;
    quiet = 1'b0;
    wait (rst_ni);
    forever begin
      if ($urandom_range(0, 49) == 0) quiet = !quiet;
      gap = quiet ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
        rx_stall <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      rx_stall <= 1'b0;
      @(posedge clk_i);
      while (!(out_valid_o && !out_stall_i)) @(posedge clk_i);
    end
  end

  // one long output hold-off while bytes keep coming, so the queue fills
  // and the block has to stall its input
  initial begin : hold_off
    wait (n_sent >= HOLD_AFTER);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  initial begin : watchdog
    wait (n_cycles >= LIMIT_CYCLES);
    $display("timeout after %0d cycles, %0d words still expected", n_cycles, in_flight);
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    logic [BYTE_W-1:0] opening[$];
    opening = '{
      8'h01, 8'h7F,                   // ascii extremes
      8'hC2, 8'h80, 8'hDF, 8'hFF,     // two-byte min and max, sloppy tail
      8'hE0, 8'h80, 8'h80,            // overlong three-byte form
      8'hEF, 8'hBF, 8'h7F,            // 0xffff through an unchecked tail
      8'hF0, 8'h90, 8'h80, 8'h80,     // first surrogate pair
      8'hF7, 8'hBF, 8'hBF, 8'hBF,     // beyond 0x10ffff, 16-bit surrogate math
      8'h00,                          // terminator
      8'hC3, 8'h00,                   // nul inside a sequence
      8'hFF, 8'h41, 8'h00,            // bad lead, muted byte, re-arm
      8'h80, 8'h00                    // stray tail byte as lead
    };
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset capacity, directed bytes first, hold-off falls in here
    foreach (opening[k]) send_byte(opening[k]);
    while (n_sent < 350) send_string();

    // tiny buffers hit buffer-too-small on the unit and on the terminator
    run_phase(21'd0, 450);
    run_phase(21'd1, 550);
    run_phase(21'd2, 650);
    run_phase(21'd3, 800);
    run_phase(CAP_W'($urandom_range(4, 40)), 950);
    // all low bits set, then the top capacity again
    run_phase(21'hFFFFF, 1150);
    run_phase(CAP_W'(MAX_CAPACITY), 1300);
    run_phase(CAP_W'($urandom_range(4, 40)), 1476);

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (in_flight != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run covered %0d input bytes under %0d capacity settings and one long hold-off",
             n_sent, n_settings);
    $display("%0d result words compared, %0d failures", words_seen, fail_count);
    if (fail_count == 0 && in_flight == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/u8u16_pkg.sv
rtl/u8u16_front.sv
rtl/u8u16_queue.sv
rtl/u8u16_back.sv
rtl/utf8_to_utf16_transcoder_core.sv
test/u8u16_unit_checker.sv
test/tb.sv
